// File: design/npc_pkg.sv
// Shared types, constants and helpers for the nearest palette color block.
// No dependencies; every other file of the block imports this package.
package npc_pkg;

   // Default palette depth, handed to the top level parameter
   localparam int PALETTE_DEPTH_DEF = 256;

   // Fixed field widths of the channels
   localparam int COMP_W      = 8;
   localparam int IDX_FIELD_W = 8;
   localparam int SIZE_W      = 9;
   localparam int SQ_W        = 2 * COMP_W;
   localparam int DIST_W      = 18;

   // Search start bound, above any real distance
   localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(3 * 256 * 256);
   // Largest distance a search can produce
   localparam logic [DIST_W-1:0] DIST_MAX   = DIST_W'(3 * 255 * 255);
   // Palette size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Transaction function codes
   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_MAP  = 1'b1
   } func_type;

   // Classified item as it travels from front to back
   typedef struct packed {
      func_type               func;
      logic [IDX_FIELD_W-1:0] entry_index;
      logic [COMP_W-1:0]      red;
      logic [COMP_W-1:0]      green;
      logic [COMP_W-1:0]      blue;
      logic [IDX_FIELD_W-1:0] last_index;
   } item_type;

   // Queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Square of the absolute difference of two color components
   function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                               input logic [COMP_W-1:0] b);
      logic [COMP_W-1:0] diff;
      diff = (a >= b) ? (a - b) : (b - a);
      return SQ_W'(diff) * SQ_W'(diff);
   endfunction

endpackage

// File: design/npc_channels.sv
// Channel interfaces of the nearest palette color block: request, response
// and configuration write. Depends on npc_pkg.
interface npc_req_if import npc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [IDX_FIELD_W-1:0] entry_index;
   logic [COMP_W-1:0]      red;
   logic [COMP_W-1:0]      green;
   logic [COMP_W-1:0]      blue;

   modport source (output valid, func, entry_index, red, green, blue, input ready);
   modport sink   (input valid, func, entry_index, red, green, blue, output ready);
endinterface

interface npc_rsp_if import npc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [IDX_FIELD_W-1:0] color_index;
   logic [DIST_W-1:0]      best_distance;

   modport source (output valid, color_index, best_distance, input ready);
   modport sink   (input valid, color_index, best_distance, output ready);
endinterface

interface npc_csr_if import npc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] palette_size;

   modport source (output valid, palette_size, input ready);
   modport sink   (input valid, palette_size, output ready);
endinterface

// File: design/npc_front.sv
// Front end: takes request and configuration transactions, holds palette_size
// and classifies each item for the back end. Depends on npc_pkg, npc_channels.
module npc_front import npc_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   npc_req_if.sink          req_chan,
   npc_csr_if.sink          csr_chan,
   input  queue_status_type q_status,
   output logic             push,
   output item_type         push_item
);

   logic [SIZE_W-1:0]      size_ff;
   logic [SIZE_W-1:0]      size_in;
   logic [IDX_FIELD_W-1:0] last_index;

   // Take configuration at any time
   assign csr_chan.ready = 1'b1;

   always_comb begin
      size_in = size_ff;
      if (csr_chan.valid) begin
         size_in = csr_chan.palette_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // Clamp the searched range to one .. PALETTE_DEPTH entries
   always_comb begin
      if (size_ff == '0) begin
         last_index = '0;
      end else if (size_ff > SIZE_W'(PALETTE_DEPTH)) begin
         last_index = IDX_FIELD_W'(PALETTE_DEPTH - 1);
      end else begin
         last_index = IDX_FIELD_W'(size_ff - SIZE_W'(1));
      end
   end

   // Push accepted transactions into the queue
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   always_comb begin
      push_item.func        = func_type'(req_chan.func);
      push_item.entry_index = req_chan.entry_index;
      push_item.red         = req_chan.red;
      push_item.green       = req_chan.green;
      push_item.blue        = req_chan.blue;
      push_item.last_index  = last_index;
   end

endmodule

// File: design/npc_queue.sv
// Short queue between front and back so each side stalls on its own.
// Depends on npc_pkg.
module npc_queue import npc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type             store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_item       = store_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/npc_back.sv
// Back end: palette memory, pipelined nearest-entry sweep and response
// register. Depends on npc_pkg, npc_channels.
module npc_back import npc_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  item_type         q_item,
   output logic             pop,
   npc_rsp_if.source        rsp_chan
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam int ENT_W = 3 * COMP_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   logic [IDX_W-1:0]     addr_ff;
   logic [IDX_W-1:0]     addr_in;
   logic [IDX_W-1:0]     last_ff;
   logic [IDX_W-1:0]     last_in;
   logic [COMP_W-1:0]    pix_r_ff;
   logic [COMP_W-1:0]    pix_g_ff;
   logic [COMP_W-1:0]    pix_b_ff;
   logic                 start_map;

   logic [ENT_W-1:0]     palette_mem [PALETTE_DEPTH];
   logic [ENT_W-1:0]     mem_q_ff;
   logic                 mem_we;

   logic                 s1_valid_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic                 s2_valid_ff;
   logic [IDX_W-1:0]     s2_idx_ff;
   logic [SQ_W-1:0]      sq_r_ff;
   logic [SQ_W-1:0]      sq_g_ff;
   logic [SQ_W-1:0]      sq_b_ff;
   logic [DIST_W-1:0]    entry_dist;

   logic [DIST_W-1:0]    best_ff;
   logic [DIST_W-1:0]    best_in;
   logic [IDX_W-1:0]     best_idx_ff;
   logic [IDX_W-1:0]     best_idx_in;

   logic                 rsp_load;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [IDX_FIELD_W-1:0] rsp_index_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;

   // Take one queued item whenever idle
   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign start_map = pop && (q_item.func == FUNC_MAP);
   assign mem_we    = pop && (q_item.func == FUNC_LOAD)
                      && ({1'b0, q_item.entry_index} < (IDX_FIELD_W + 1)'(PALETTE_DEPTH));
   assign rsp_load  = (state_ff == ST_DRAIN) && !s1_valid_ff && !s2_valid_ff
                      && (!rsp_valid_ff || rsp_chan.ready);

   // Sequence the sweep
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_map) begin
               addr_in  = '0;
               last_in  = q_item.last_index[IDX_W-1:0];
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            addr_in = addr_ff + IDX_W'(1);
            if (addr_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= (state_ff == ST_SWEEP);
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      last_ff <= last_in;
      if (start_map) begin
         pix_r_ff <= q_item.red;
         pix_g_ff <= q_item.green;
         pix_b_ff <= q_item.blue;
      end
   end

   // Palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[q_item.entry_index[IDX_W-1:0]] <= {q_item.red, q_item.green,
                                                         q_item.blue};
      end
      mem_q_ff  <= palette_mem[addr_ff];
      s1_idx_ff <= addr_ff;
   end

   // Square the component differences
   always_ff @(posedge clock) begin
      sq_r_ff   <= sq_diff(mem_q_ff[3*COMP_W-1:2*COMP_W], pix_r_ff);
      sq_g_ff   <= sq_diff(mem_q_ff[2*COMP_W-1:COMP_W], pix_g_ff);
      sq_b_ff   <= sq_diff(mem_q_ff[COMP_W-1:0], pix_b_ff);
      s2_idx_ff <= s1_idx_ff;
   end

   // Sum and keep the strictly closer entry
   assign entry_dist = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (start_map) begin
         best_in     = DIST_BOUND;
         best_idx_in = '0;
      end else if (s2_valid_ff && (entry_dist < best_ff)) begin
         best_in     = entry_dist;
         best_idx_in = s2_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // Hold the response until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= IDX_FIELD_W'(best_idx_ff);
         rsp_dist_ff  <= best_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.color_index   = rsp_index_ff;
   assign rsp_chan.best_distance = rsp_dist_ff;

endmodule

// File: design/nearest_palette_color.sv
// Load transaction: queued on acceptance, written to the palette when the back end pops it.
// Map transaction: the sweep reads one palette entry per cycle from the single read port,
// and the back end takes no further item from the queue until the result is loaded into
// the response register. A two-entry queue keeps taking requests meanwhile until full.
// Synchronous reset clears control state and sets palette_size to 256; palette
// contents stay undefined until loaded.
module nearest_palette_color import npc_pkg::*; #(
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   npc_req_if.sink   req_chan,
   npc_rsp_if.source rsp_chan,
   npc_csr_if.sink   csr_chan
);

   queue_status_type q_status;
   logic             push;
   item_type         push_item;
   logic             pop;
   item_type         q_item;

   // Accept and classify
   npc_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   // Decouple front and back
   npc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (q_item),
      .q_status  (q_status)
   );

   // Load palette and search it
   npc_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_item   (q_item),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: design/npc_checker.sv
// Port-level checks for nearest_palette_color, attached by bind.
// Depends on npc_pkg and the top level.
module npc_checker import npc_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [IDX_FIELD_W-1:0] color_index,
   input logic [DIST_W-1:0]      best_distance,
   input logic                   csr_valid,
   input logic                   csr_ready
);

   // Reset drops any pending response
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(color_index)
                                  && $stable(best_distance))
      else $error("stalled response changed");

   // Distance never exceeds the largest RGB distance
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> best_distance <= DIST_MAX)
      else $error("distance out of range");

   // Configuration writes never stall
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write stalled");

endmodule

bind nearest_palette_color npc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .color_index   (rsp_chan.color_index),
   .best_distance (rsp_chan.best_distance),
   .csr_valid     (csr_chan.valid),
   .csr_ready     (csr_chan.ready)
);

// File: test/nearest_palette_color_checker.sv
`timescale 1ns / 100ps
// Scoreboard for nearest_palette_color: mirrors the palette and the search size,
// predicts every pixel lookup and compares the results.
// Depends on npc_pkg and npc_channels.
module nearest_palette_color_checker import npc_pkg::*; (
   input  logic clock,
   input  logic reset,
   npc_req_if   req_chan,
   npc_rsp_if   rsp_chan,
   npc_csr_if   csr_chan,
   output int   failures,
   output int   pending,
   output int   lookups_checked
);

   localparam int SEARCH_BOUND = 3 * 256 * 256;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0] color_index;
      logic [DIST_W-1:0]      best_distance;
   } lookup_result_type;

   logic [3*COMP_W-1:0] palette_copy [PALETTE_DEPTH_DEF];
   logic [SIZE_W-1:0]   search_size;
   lookup_result_type   expected_lookups [$];

   // Walk the searched entries; a later entry wins only when strictly closer
   function automatic lookup_result_type closest_entry(input logic [COMP_W-1:0] red,
                                                       input logic [COMP_W-1:0] green,
                                                       input logic [COMP_W-1:0] blue);
      int span;
      int best;
      int sq_sum;
      int dr;
      int dg;
      int db;
      lookup_result_type found;
      span = int'(search_size);
      if (span == 0) begin
         span = 1;
      end
      if (span > PALETTE_DEPTH_DEF) begin
         span = PALETTE_DEPTH_DEF;
      end
      best = SEARCH_BOUND;
      found.color_index = '0;
      for (int k = 0; k < span; k++) begin
         dr = int'(palette_copy[k][3*COMP_W-1:2*COMP_W]) - int'(red);
         dg = int'(palette_copy[k][2*COMP_W-1:COMP_W]) - int'(green);
         db = int'(palette_copy[k][COMP_W-1:0]) - int'(blue);
         sq_sum = dr * dr + dg * dg + db * db;
         if (sq_sum < best) begin
            best = sq_sum;
            found.color_index = IDX_FIELD_W'(k);
         end
      end
      found.best_distance = DIST_W'(best);
      return found;
   endfunction

   initial begin
      failures        = 0;
      pending         = 0;
      lookups_checked = 0;
      search_size     = SIZE_RESET;
   end

   // Sample all three channels at the rising edge
   always @(posedge clock) begin : watch
      lookup_result_type want;
      if (reset) begin
         search_size = SIZE_RESET;
         expected_lookups.delete();
      end else begin
         // Track size register writes
         if (csr_chan.valid && csr_chan.ready) begin
            search_size = csr_chan.palette_size;
         end
         // Store loads, predict lookups
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.func == FUNC_LOAD) begin
               palette_copy[req_chan.entry_index] = {req_chan.red, req_chan.green,
                                                     req_chan.blue};
            end else begin
               expected_lookups.insert(expected_lookups.size(),
                                       closest_entry(req_chan.red, req_chan.green,
                                                     req_chan.blue));
            end
         end
         // Compare each result transaction with the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_lookups.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("unexpected lookup result: index %0d distance %0d",
                           rsp_chan.color_index, rsp_chan.best_distance);
               end
            end else begin
               want = expected_lookups.pop_front();
               lookups_checked++;
               if (rsp_chan.color_index !== want.color_index ||
                   rsp_chan.best_distance !== want.best_distance) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display({"lookup mismatch: expected index %0d distance %0d,",
                               " got index %0d distance %0d"},
                              want.color_index, want.best_distance,
                              rsp_chan.color_index, rsp_chan.best_distance);
                  end
               end
            end
         end
      end
      pending = expected_lookups.size();
   end

endmodule

// File: test/nearest_palette_color_tb.sv
`timescale 1ns / 100ps
// Top of the nearest_palette_color testbench: clock, reset, palette and pixel
// stimulus, throttling and verdict. Depends on npc_pkg, npc_channels and the checker.
module nearest_palette_color_tb;
   import npc_pkg::*;

   localparam int PHASE_ITEMS   = 140;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 300;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_SIZES [PHASE_COUNT] = '{2, 16, 3, 64, 256, 511, 7, 1, 0, 40, 257, 12};

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   int   lookups_checked;
   int   send_idle;
   int   recv_stall;
   int   loads_sent;
   int   maps_sent;

   // Stimulus-side record of what was loaded, used to aim pixels and ties
   logic [3*COMP_W-1:0] shadow [PALETTE_DEPTH_DEF];
   bit                  loaded [PALETTE_DEPTH_DEF];

   npc_req_if req_chan ();
   npc_rsp_if rsp_chan ();
   npc_csr_if csr_chan ();

   nearest_palette_color dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   nearest_palette_color_checker lookup_check (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_chan        (csr_chan),
      .failures        (failures),
      .pending         (pending),
      .lookups_checked (lookups_checked)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Throttle the result channel
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
   end

   // Present one transaction and hold it until accepted
   task automatic send_item(input func_type op, input logic [IDX_FIELD_W-1:0] idx,
                            input logic [3*COMP_W-1:0] color);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.func        <= op;
      req_chan.entry_index <= idx;
      req_chan.red         <= color[3*COMP_W-1:2*COMP_W];
      req_chan.green       <= color[2*COMP_W-1:COMP_W];
      req_chan.blue        <= color[COMP_W-1:0];
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic load_entry(input logic [IDX_FIELD_W-1:0] idx,
                             input logic [3*COMP_W-1:0] color);
      shadow[idx] = color;
      loaded[idx] = 1'b1;
      loads_sent++;
      send_item(FUNC_LOAD, idx, color);
   endtask

   // Entry index is ignored on lookups, so fill it with noise
   task automatic map_pixel(input logic [3*COMP_W-1:0] color);
      maps_sent++;
      send_item(FUNC_MAP, IDX_FIELD_W'($urandom_range(255)), color);
   endtask

   // Hold off the sender until every lookup has come back
   task automatic drain_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   // Write the size register with the block idle
   task automatic set_palette_size(input logic [SIZE_W-1:0] size_value);
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_chan.valid        <= 1'b1;
      csr_chan.palette_size <= size_value;
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [COMP_W-1:0] nudge(input logic [COMP_W-1:0] comp);
      int v;
      v = int'(comp) + int'($urandom_range(6)) - 3;
      if (v < 0) begin
         v = 0;
      end
      if (v > 255) begin
         v = 255;
      end
      return COMP_W'(v);
   endfunction

   // One size setting: fill the searched range, then mixed loads and lookups
   task automatic run_phase(input int size_value);
      int span;
      int src;
      logic [IDX_FIELD_W-1:0] idx;
      logic [3*COMP_W-1:0]    color;
      set_palette_size(SIZE_W'(size_value));
      span = (size_value == 0) ? 1 :
             (size_value > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : size_value;
      // Never let a lookup read an entry that was not loaded
      for (int k = 0; k < span; k++) begin
         if (!loaded[k]) begin
            load_entry(IDX_FIELD_W'(k), 24'($urandom));
         end
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n == PHASE_ITEMS / 2) begin
            drain_results();
         end
         src = $urandom_range(span - 1);
         if ($urandom_range(99) < 40) begin
            // Half the loads aim inside the searched range, the rest anywhere; some copy a color to force ties
            idx = $urandom_range(1) ? IDX_FIELD_W'($urandom_range(255))
                                    : IDX_FIELD_W'($urandom_range(span - 1));
            color = ($urandom_range(4) == 0) ? shadow[src] : 24'($urandom);
            load_entry(idx, color);
         end else begin
            case ($urandom_range(3))
               0: color = 24'($urandom);
               1: color = shadow[src];
               2: color = {nudge(shadow[src][3*COMP_W-1:2*COMP_W]),
                           nudge(shadow[src][2*COMP_W-1:COMP_W]),
                           nudge(shadow[src][COMP_W-1:0])};
               default: color = {$urandom_range(1) ? 8'hFF : 8'h00,
                                 $urandom_range(1) ? 8'hFF : 8'h00,
                                 $urandom_range(1) ? 8'hFF : 8'h00};
            endcase
            map_pixel(color);
         end
      end
   endtask

   initial begin
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.func         = FUNC_LOAD;
      req_chan.entry_index  = '0;
      req_chan.red          = '0;
      req_chan.green        = '0;
      req_chan.blue         = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.palette_size = '0;
      send_idle             = 0;
      recv_stall            = 0;
      loads_sent            = 0;
      maps_sent             = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Size zero searches entry 0 alone
      set_palette_size(SIZE_W'(0));
      load_entry(8'd0, 24'h000000);
      map_pixel(24'h000000);
      // Farthest pixel still beats the start bound
      map_pixel(24'hFFFFFF);
      load_entry(8'd1, 24'hFFFFFF);
      load_entry(8'd2, 24'hFFFFFF);
      load_entry(8'd3, 24'h804020);
      load_entry(8'd255, 24'hAA55AA);
      set_palette_size(SIZE_W'(4));
      // Entries 1 and 2 tie: the lower index must win
      map_pixel(24'hFFFFFF);
      map_pixel(24'hC8C8C8);
      map_pixel(24'h804020);
      map_pixel(24'h7F7F7F);
      map_pixel(24'h00FF00);
      map_pixel(24'hFF00FF);

      // Random phases, cycling through the throttle modes
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 84; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 84; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         run_phase(PHASE_SIZES[p]);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Ran %0d palette loads and %0d pixel lookups (%0d checked) over %0d size settings,",
               loads_sent, maps_sent, lookups_checked, PHASE_COUNT + 2);
      $display("from size 0 to 511, with tied entries, full searches and all throttle modes.");
      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #50_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: nearest_palette_color.f
design/npc_pkg.sv
design/npc_channels.sv
design/npc_front.sv
design/npc_queue.sv
design/npc_back.sv
design/nearest_palette_color.sv
design/npc_checker.sv
test/nearest_palette_color_checker.sv
test/nearest_palette_color_tb.sv
